/* hw/rtl/gtr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtr_pkg: shared types and text constants for the glob-to-regex translator
// Holds the channel payload types, the job word passed from front to back,
// the segment codes and the fixed regex fragments that the back end emits.
// ---------------------------------------------------------------------------
package gtr_pkg;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_pattern;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic match_dir_entries;
      logic match_all_children;
   } cfg_type;

   // Segment codes double as bit positions in the job mask; the back end
   // emits segments in ascending order.
   typedef enum logic [3:0] {
      SEG_STAR      = 4'd0,
      SEG_DSTAR     = 4'd1,
      SEG_ESC       = 4'd2,
      SEG_SYM       = 4'd3,
      SEG_DIR_SLASH = 4'd4,
      SEG_DIR_OTHER = 4'd5,
      SEG_ALL_SLASH = 4'd6,
      SEG_ALL_OTHER = 4'd7,
      SEG_NUL       = 4'd8
   } seg_type;

   localparam int SEG_COUNT = 9;

   typedef logic [SEG_COUNT-1:0] seg_mask_type;
   typedef logic [3:0]           seg_pos_type;

   typedef struct packed {
      seg_mask_type mask;
      logic [7:0]   symbol;
   } job_type;

   localparam int CSR_DIR_ENTRIES  = 0;
   localparam int CSR_ALL_CHILDREN = 1;

   localparam logic [7:0] CHAR_STAR  = 8'h2a;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_BSL   = 8'h5c;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam int STAR_LEN      = 5;
   localparam int DSTAR_LEN     = 2;
   localparam int DIR_SLASH_LEN = 8;
   localparam int DIR_OTHER_LEN = 12;
   localparam int ALL_OTHER_LEN = 6;

   localparam logic [8*STAR_LEN-1:0]      STAR_TXT      = "[^/]*";
   localparam logic [8*DSTAR_LEN-1:0]     DSTAR_TXT     = ".*";
   localparam logic [8*DIR_SLASH_LEN-1:0] DIR_SLASH_TXT = "[^\\/]*/?";
   localparam logic [8*DIR_OTHER_LEN-1:0] DIR_OTHER_TXT = "(/[^\\/]*)?/?";
   localparam logic [8*ALL_OTHER_LEN-1:0] ALL_OTHER_TXT = "(/.*)?";

   function automatic logic is_meta(input logic [7:0] c);
      is_meta = (c == 8'h5c) || (c == 8'h2e) || (c == 8'h5e) || (c == 8'h24) ||
                (c == 8'h5b) || (c == 8'h5d) || (c == 8'h28) || (c == 8'h29) ||
                (c == 8'h7b) || (c == 8'h7d) || (c == 8'h2b) || (c == 8'h3f) ||
                (c == 8'h7c);
   endfunction

   function automatic seg_pos_type seg_len(input seg_type seg);
      unique case (seg)
         SEG_STAR:      seg_len = seg_pos_type'(STAR_LEN);
         SEG_DSTAR:     seg_len = seg_pos_type'(DSTAR_LEN);
         SEG_DIR_SLASH: seg_len = seg_pos_type'(DIR_SLASH_LEN);
         SEG_DIR_OTHER: seg_len = seg_pos_type'(DIR_OTHER_LEN);
         SEG_ALL_SLASH: seg_len = seg_pos_type'(DSTAR_LEN);
         SEG_ALL_OTHER: seg_len = seg_pos_type'(ALL_OTHER_LEN);
         default:       seg_len = seg_pos_type'(1);
      endcase
   endfunction

   // Byte at position pos (from the left) of a segment.
   function automatic logic [7:0] seg_byte(input seg_type seg, input seg_pos_type pos,
                                           input logic [7:0] symbol);
      unique case (seg)
         SEG_STAR:      seg_byte = STAR_TXT[8*(STAR_LEN-1-int'(pos)) +: 8];
         SEG_DSTAR:     seg_byte = DSTAR_TXT[8*(DSTAR_LEN-1-int'(pos)) +: 8];
         SEG_ESC:       seg_byte = CHAR_BSL;
         SEG_SYM:       seg_byte = symbol;
         SEG_DIR_SLASH: seg_byte = DIR_SLASH_TXT[8*(DIR_SLASH_LEN-1-int'(pos)) +: 8];
         SEG_DIR_OTHER: seg_byte = DIR_OTHER_TXT[8*(DIR_OTHER_LEN-1-int'(pos)) +: 8];
         SEG_ALL_SLASH: seg_byte = DSTAR_TXT[8*(DSTAR_LEN-1-int'(pos)) +: 8];
         SEG_ALL_OTHER: seg_byte = ALL_OTHER_TXT[8*(ALL_OTHER_LEN-1-int'(pos)) +: 8];
         default:       seg_byte = CHAR_NUL;
      endcase
   endfunction

endpackage

/* hw/rtl/gtr_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtr_front: pattern byte classifier
// Accepts glob bytes, tracks the held star and whether the output so far ends
// in a slash, and turns each byte into a job mask of regex segments.
// ---------------------------------------------------------------------------
module gtr_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  gtr_pkg::req_type req_data,
   input  gtr_pkg::cfg_type cfg,
   input  logic            queue_full,
   output logic            push_valid,
   output gtr_pkg::job_type push_job
);

   logic star_held_ff, star_held_in;
   logic slash_ff, slash_in;
   logic accept;
   logic is_end;
   logic slash_now;
   logic slash_after_dir;
   gtr_pkg::seg_mask_type mask;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_end    = req_data.end_of_pattern || (req_data.symbol == gtr_pkg::CHAR_NUL);

   always_comb begin
      mask            = '0;
      star_held_in    = star_held_ff;
      slash_in        = slash_ff;
      slash_now       = star_held_ff ? 1'b0 : slash_ff;
      slash_after_dir = cfg.match_dir_entries ? 1'b0 : slash_now;
      if (is_end) begin
         mask[gtr_pkg::SEG_STAR] = star_held_ff;
         if (cfg.match_dir_entries) begin
            mask[gtr_pkg::SEG_DIR_SLASH] = slash_now;
            mask[gtr_pkg::SEG_DIR_OTHER] = !slash_now;
         end
         if (cfg.match_all_children) begin
            mask[gtr_pkg::SEG_ALL_SLASH] = slash_after_dir;
            mask[gtr_pkg::SEG_ALL_OTHER] = !slash_after_dir;
         end
         mask[gtr_pkg::SEG_NUL] = 1'b1;
         star_held_in = 1'b0;
         slash_in     = 1'b0;
      end else if (star_held_ff && req_data.symbol == gtr_pkg::CHAR_STAR) begin
         mask[gtr_pkg::SEG_DSTAR] = 1'b1;
         star_held_in = 1'b0;
         slash_in     = 1'b0;
      end else if (req_data.symbol == gtr_pkg::CHAR_STAR) begin
         // A lone star waits for the next byte before it can be expanded.
         star_held_in = 1'b1;
      end else begin
         mask[gtr_pkg::SEG_STAR] = star_held_ff;
         mask[gtr_pkg::SEG_ESC]  = gtr_pkg::is_meta(req_data.symbol);
         mask[gtr_pkg::SEG_SYM]  = 1'b1;
         star_held_in = 1'b0;
         slash_in     = (req_data.symbol == gtr_pkg::CHAR_SLASH);
      end
   end

   assign push_valid      = accept && (mask != '0);
   assign push_job.mask   = mask;
   assign push_job.symbol = req_data.symbol;

   always_ff @(posedge clock) begin
      if (reset) begin
         star_held_ff <= 1'b0;
         slash_ff     <= 1'b0;
      end else if (accept) begin
         star_held_ff <= star_held_in;
         slash_ff     <= slash_in;
      end
   end

endmodule

/* hw/rtl/gtr_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtr_queue: job queue between classifier and emitter
// A small first-in first-out buffer of job words with a registered count.
// ---------------------------------------------------------------------------
module gtr_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  gtr_pkg::job_type push_job,
   output logic             full,
   output logic             pop_ready,
   input  logic             pop,
   output gtr_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gtr_pkg::job_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_ready = (count_ff != '0);
   assign pop_job   = store_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/gtr_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtr_back: regex byte emitter
// Walks the segments of the current job one byte per cycle while the output
// is not stalled, and drives the registered result word.
// ---------------------------------------------------------------------------
module gtr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_ready,
   input  gtr_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gtr_pkg::rsp_type rsp_data
);

   gtr_pkg::seg_mask_type mask_ff, mask_in, mask_rest;
   logic [7:0]            symbol_ff, symbol_in;
   gtr_pkg::seg_pos_type  pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gtr_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   gtr_pkg::seg_type      cur_seg;
   logic                  advance;
   logic                  seg_done;

   // Lowest set bit of the mask is the segment being emitted.
   always_comb begin
      cur_seg = gtr_pkg::SEG_NUL;
      for (int i = gtr_pkg::SEG_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur_seg = gtr_pkg::seg_type'(4'(i));
         end
      end
   end

   assign advance  = (mask_ff != '0) && (!rsp_valid_ff || !rsp_stall);
   assign seg_done = advance && (pos_ff == gtr_pkg::seg_len(cur_seg) - 1'b1);

   always_comb begin
      mask_rest = mask_ff;
      if (seg_done) begin
         mask_rest[cur_seg] = 1'b0;
      end
      job_pop   = (mask_rest == '0) && job_ready;
      mask_in   = mask_rest;
      symbol_in = symbol_ff;
      pos_in    = pos_ff;
      if (seg_done) begin
         pos_in = '0;
      end else if (advance) begin
         pos_in = pos_ff + 1'b1;
      end
      if (job_pop) begin
         mask_in   = job_head.mask;
         symbol_in = job_head.symbol;
         pos_in    = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_char = gtr_pkg::seg_byte(cur_seg, pos_ff, symbol_ff);
         rsp_data_in.last     = (cur_seg == gtr_pkg::SEG_NUL);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff   <= symbol_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/glob_to_regex_translator_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glob_to_regex_translator_unit: glob pattern to regex text translator
// Translates a glob pattern byte stream into regex text, one byte per word,
// ending each pattern with a NUL word flagged as last.
//
//   Channel  Direction  Handshake          Word
//   req_     in         valid / stall      one glob byte or end marker
//   rsp_     out        valid / stall      one regex byte, last on NUL
//   csr_     in         valid / ready      register index and data
//
// The output emits one byte per cycle while not stalled; an input byte that
// expands to N regex bytes occupies the emitter until all N are out. The input takes
// one byte per cycle until the job queue (QUEUE_DEPTH entries) fills.
// Reset is synchronous and clears the star flag, the queue and the output.
// A stalled output holds its word while the queue keeps absorbing input until it fills.
// ---------------------------------------------------------------------------
module glob_to_regex_translator_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gtr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gtr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic             csr_data
);

   gtr_pkg::cfg_type cfg_ff, cfg_in;
   logic             queue_full;
   logic             push_valid;
   gtr_pkg::job_type push_job;
   logic             job_ready;
   logic             job_pop;
   gtr_pkg::job_type job_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == 1'(gtr_pkg::CSR_DIR_ENTRIES)) begin
            cfg_in.match_dir_entries = csr_data;
         end else begin
            cfg_in.match_all_children = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   gtr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_ready  (job_ready),
      .pop        (job_pop),
      .pop_job    (job_head)
   );

   gtr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (job_ready),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
